// ===== src/nbm_irq_pkg.sv =====
// ----------------------------------------------------------------------------
// nbm_irq_pkg
// Shared types, register decode keys and helper functions for the nibble
// bank mapper with interrupt down-counter.
// ----------------------------------------------------------------------------
package nbm_irq_pkg;

  // Bank slot counts
  localparam int unsigned CharSlots = 8;
  localparam int unsigned PrgSlots  = 3;

  // Widths
  localparam int unsigned BankW  = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned AddrW  = 16;

  // Reset value of the program bank count
  localparam logic [CountW-1:0] PrgCountReset = 9'd16;
  localparam logic [CountW-1:0] PrgCountMax   = 9'd256;

  // Item opcodes
  typedef enum logic [1:0] {
    OpWrite      = 2'd0,
    OpTick       = 2'd1,
    OpPrgLookup  = 2'd2,
    OpChrLookup  = 2'd3
  } opcode_e;

  // Counter width select codes
  typedef enum logic [1:0] {
    Width16 = 2'd0,
    Width12 = 2'd1,
    Width8  = 2'd2,
    Width4  = 2'd3
  } width_sel_e;

  // Register decode key: {address[15:12], address[1:0]}
  localparam logic [5:0] KeyPrg0Lo = {4'h8, 2'b00};
  localparam logic [5:0] KeyPrg0Hi = {4'h8, 2'b01};
  localparam logic [5:0] KeyPrg1Lo = {4'h8, 2'b10};
  localparam logic [5:0] KeyPrg1Hi = {4'h8, 2'b11};
  localparam logic [5:0] KeyPrg2Lo = {4'h9, 2'b00};
  localparam logic [5:0] KeyPrg2Hi = {4'h9, 2'b01};
  localparam logic [5:0] KeyLatch0 = {4'hE, 2'b00};
  localparam logic [5:0] KeyLatch1 = {4'hE, 2'b01};
  localparam logic [5:0] KeyLatch2 = {4'hE, 2'b10};
  localparam logic [5:0] KeyLatch3 = {4'hE, 2'b11};
  localparam logic [5:0] KeyReload = {4'hF, 2'b00};
  localparam logic [5:0] KeyCtrl   = {4'hF, 2'b01};
  localparam logic [5:0] KeyMirror = {4'hF, 2'b10};

  // Input item
  typedef struct packed {
    opcode_e          opcode;
    logic [AddrW-1:0] bus_address;
    logic [7:0]       write_data;
    logic [15:0]      elapsed_cycles;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic             irq_line;
    logic [BankW-1:0] bank_number;
    logic [1:0]       mirror_mode;
  } out_item_t;

  // Replace one nibble of a bank byte
  function automatic logic [7:0] put_half(input logic [7:0] cur, input logic [3:0] nib,
                                          input logic high);
    logic [7:0] res;
    if (high) begin
      res = {nib, cur[3:0]};
    end else begin
      res = {cur[7:4], nib};
    end
    return res;
  endfunction

  // Active counter bits for a width code
  function automatic logic [15:0] width_mask(input width_sel_e sel);
    logic [15:0] m;
    case (sel)
      Width16: m = 16'hFFFF;
      Width12: m = 16'h0FFF;
      Width8:  m = 16'h00FF;
      Width4:  m = 16'h000F;
      default: m = 16'hFFFF;
    endcase
    return m;
  endfunction

  // Four restoring remainder steps; rem_in < div, div in 1..256
  function automatic logic [7:0] mod_step4(input logic [7:0] rem_in, input logic [3:0] bits,
                                           input logic [CountW-1:0] div);
    logic [CountW-1:0] r;
    r = {1'b0, rem_in};
    for (int i = 3; i >= 0; i--) begin
      r = {r[7:0], bits[i]};
      if (r >= div) begin
        r = r - div;
      end
    end
    return r[7:0];
  endfunction

endpackage

// ===== src/nibble_bank_mapper_irq_counter.sv =====
// ----------------------------------------------------------------------------
// nibble_bank_mapper_irq_counter
// Bank mapper with nibble-wide bank registers, reload latch, mirroring and
// an interrupt down-counter of selectable width; answers bank lookups.
// ----------------------------------------------------------------------------
// Stages: capture, then high and low remainder nibble, between accept and
// result valid. Throughput: one item per cycle while the output is not
// stalled; state is updated in the accept cycle. The program bank modulo
// runs as a two-stage restoring remainder pipe (four steps per stage).
// Reset: async active low; all bank registers, latch, counter and control
// clear, program bank count returns to 16.
module nibble_bank_mapper_irq_counter
  import nbm_irq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o
);

  // Mapper state
  logic [CountW-1:0] prg_count_q;
  logic [BankW-1:0]  prg_banks_q [PrgSlots];
  logic [BankW-1:0]  prg_banks_d [PrgSlots];
  logic [BankW-1:0]  chr_banks_q [CharSlots];
  logic [BankW-1:0]  chr_banks_d [CharSlots];
  logic [1:0]        mirroring_q, mirroring_d;
  logic [15:0]       reload_latch_q, reload_latch_d;
  logic [15:0]       down_counter_q, down_counter_d;
  width_sel_e        width_sel_q, width_sel_d;
  logic              count_en_q, count_en_d;
  logic              irq_pending_q, irq_pending_d;

  // Pipeline stages
  logic              v1_q, v2_q, v3_q;
  logic              rdy1, rdy2, rdy3;
  logic              in_accept;
  logic              s1_irq_q, s2_irq_q;
  logic [1:0]        s1_mirror_q, s2_mirror_q;
  logic [BankW-1:0]  s1_bank_q;
  logic [CountW-1:0] s1_div_q, s2_div_q;
  logic [7:0]        s2_rem_q;
  logic [3:0]        s2_low_q;
  out_item_t         s3_q;

  // Decode helpers
  logic [3:0]        nib;
  logic [3:0]        group;
  logic [5:0]        wr_key;
  logic              wr_high;
  logic [2:0]        chr_wr_idx;
  logic [15:0]       mask;
  logic [15:0]       active;
  logic [15:0]       cnt_next;
  logic [CountW-1:0] eff_count;
  logic [BankW-1:0]  bank_raw;
  logic [CountW-1:0] div_d;
  logic [AddrW-1:0]  addr;

  // Handshake: each stage moves when empty or when the next one moves
  assign rdy3       = ~v3_q | out_ready_i;
  assign rdy2       = ~v2_q | rdy3;
  assign rdy1       = ~v1_q | rdy2;
  assign in_ready_o = rdy1;
  assign in_accept  = in_valid_i & rdy1;

  assign addr       = in_data_i.bus_address;
  assign nib        = in_data_i.write_data[3:0];
  assign group      = addr[15:12];
  assign wr_key     = {addr[15:12], addr[1:0]};
  assign wr_high    = addr[0];
  // character slot: (group - 0xA) * 2 + A1
  assign chr_wr_idx = {group[1:0] ^ 2'b10, addr[1]};

  // Tick arithmetic on the active counter bits
  assign mask     = width_mask(width_sel_q);
  assign active   = down_counter_q & mask;
  assign cnt_next = (active - in_data_i.elapsed_cycles) & mask;

  // Program bank count clamped to 1..256
  always_comb begin
    if (prg_count_q == '0) begin
      eff_count = CountW'(1);
    end else if (prg_count_q > PrgCountMax) begin
      eff_count = PrgCountMax;
    end else begin
      eff_count = prg_count_q;
    end
  end

  // State update for writes and ticks
  always_comb begin
    prg_banks_d    = prg_banks_q;
    chr_banks_d    = chr_banks_q;
    mirroring_d    = mirroring_q;
    reload_latch_d = reload_latch_q;
    down_counter_d = down_counter_q;
    width_sel_d    = width_sel_q;
    count_en_d     = count_en_q;
    irq_pending_d  = irq_pending_q;
    if (in_accept && in_data_i.opcode == OpWrite) begin
      if (group >= 4'hA && group <= 4'hD) begin
        chr_banks_d[chr_wr_idx] = put_half(chr_banks_q[chr_wr_idx], nib, wr_high);
      end else begin
        case (wr_key)
          KeyPrg0Lo, KeyPrg0Hi: begin
            prg_banks_d[0] = put_half(prg_banks_q[0], nib, wr_high);
          end
          KeyPrg1Lo, KeyPrg1Hi: begin
            prg_banks_d[1] = put_half(prg_banks_q[1], nib, wr_high);
          end
          KeyPrg2Lo, KeyPrg2Hi: begin
            prg_banks_d[2] = put_half(prg_banks_q[2], nib, wr_high);
          end
          KeyLatch0: reload_latch_d[3:0]   = nib;
          KeyLatch1: reload_latch_d[7:4]   = nib;
          KeyLatch2: reload_latch_d[11:8]  = nib;
          KeyLatch3: reload_latch_d[15:12] = nib;
          KeyReload: begin
            down_counter_d = reload_latch_q;
            irq_pending_d  = 1'b0;
          end
          KeyCtrl: begin
            irq_pending_d = 1'b0;
            count_en_d    = nib[0];
            if (nib[3]) begin
              width_sel_d = Width4;
            end else if (nib[2]) begin
              width_sel_d = Width8;
            end else if (nib[1]) begin
              width_sel_d = Width12;
            end else begin
              width_sel_d = Width16;
            end
          end
          KeyMirror: mirroring_d = nib[1:0];
          default: ;
        endcase
      end
    end else if (in_accept && in_data_i.opcode == OpTick && count_en_q) begin
      if ({1'b0, in_data_i.elapsed_cycles} > {1'b0, active}) begin
        irq_pending_d = 1'b1;
      end
      down_counter_d = (down_counter_q & ~mask) | cnt_next;
    end
  end

  // Lookup: raw bank and divisor; 256 leaves the bank unchanged
  always_comb begin
    bank_raw = '0;
    div_d    = PrgCountMax;
    case (in_data_i.opcode)
      OpPrgLookup: begin
        if (!addr[15]) begin
          bank_raw = '0;
        end else if (addr[15:13] == 3'b111) begin
          bank_raw = BankW'(eff_count - CountW'(1));
        end else begin
          div_d = eff_count;
          case (addr[14:13])
            2'd0:    bank_raw = prg_banks_q[0];
            2'd1:    bank_raw = prg_banks_q[1];
            default: bank_raw = prg_banks_q[2];
          endcase
        end
      end
      OpChrLookup: begin
        if (addr[13]) begin
          bank_raw = '0;
        end else begin
          bank_raw = chr_banks_q[addr[12:10]];
        end
      end
      default: bank_raw = '0;
    endcase
  end

  // Configuration and mapper state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q    <= PrgCountReset;
      mirroring_q    <= '0;
      reload_latch_q <= '0;
      down_counter_q <= '0;
      width_sel_q    <= Width16;
      count_en_q     <= 1'b0;
      irq_pending_q  <= 1'b0;
      for (int i = 0; i < PrgSlots; i++) begin
        prg_banks_q[i] <= '0;
      end
      for (int i = 0; i < CharSlots; i++) begin
        chr_banks_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        prg_count_q <= cfg_wdata_i;
      end
      mirroring_q    <= mirroring_d;
      reload_latch_q <= reload_latch_d;
      down_counter_q <= down_counter_d;
      width_sel_q    <= width_sel_d;
      count_en_q     <= count_en_d;
      irq_pending_q  <= irq_pending_d;
      prg_banks_q    <= prg_banks_d;
      chr_banks_q    <= chr_banks_d;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_accept;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Stage payloads: capture, high remainder nibble, low remainder nibble
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_irq_q    <= irq_pending_d;
      s1_mirror_q <= mirroring_d;
      s1_bank_q   <= bank_raw;
      s1_div_q    <= div_d;
    end
    if (rdy2) begin
      s2_irq_q    <= s1_irq_q;
      s2_mirror_q <= s1_mirror_q;
      s2_rem_q    <= mod_step4(8'd0, s1_bank_q[7:4], s1_div_q);
      s2_low_q    <= s1_bank_q[3:0];
      s2_div_q    <= s1_div_q;
    end
    if (rdy3) begin
      s3_q.irq_line    <= s2_irq_q;
      s3_q.mirror_mode <= s2_mirror_q;
      s3_q.bank_number <= mod_step4(s2_rem_q, s2_low_q, s2_div_q);
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = s3_q;

  // Checks
  a_reload_clears_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.opcode == OpWrite && wr_key == KeyReload |=> !irq_pending_q)
    else $error("irq still pending after counter reload");

  a_tick_disabled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.opcode == OpTick && !count_en_q |=> $stable(down_counter_q))
    else $error("counter moved while disabled");

  a_tick_upper_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.opcode == OpTick && width_sel_q == Width4
    |=> down_counter_q[15:4] == $past(down_counter_q[15:4]))
    else $error("counter bits above active width changed");

  a_partial_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> ({1'b0, s2_rem_q} < s2_div_q))
    else $error("partial remainder not below divisor");

endmodule
